// ----- hdl/bpc_pkg.sv -----
// Shared types, constants and the arctangent table of the pose correction block.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_GAIN  = 2'd0;
  localparam logic [1:0] CFG_SHIFT = 2'd1;
  localparam logic [1:0] CFG_TURN  = 2'd2;

  // Register reset values
  localparam logic [16:0] GAIN_RST  = 17'd65536;
  localparam logic [30:0] SHIFT_RST = 31'd65536;
  localparam logic [14:0] TURN_RST  = 15'd32767;

  // Gain of 1.0 in Q1.16
  localparam logic [16:0] GAIN_ONE = 17'd65536;

  // CORDIC start value (Q2.30 gain compensation) and step count
  localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;
  localparam int unsigned        CORDIC_STEPS = 16;

  // One raw input word
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] ph;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [15:0] mh;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
  } pose_in_t;

  // Queued word: raw input plus the yaw and gain worked out on accept
  typedef struct packed {
    pose_in_t           raw;
    logic signed [15:0] yaw;
    logic [16:0]        alpha;
  } item_t;

  // Request to the shared sine/cosine unit
  typedef struct packed {
    logic               go;
    logic signed [15:0] angle;
  } cord_req_t;

  // Answer of the sine/cosine unit, Q2.30
  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
  } cord_rsp_t;

  // Arctangent of 2^-i in binary-angle units
  function automatic logic signed [16:0] atan_val(input logic [3:0] i);
    logic signed [16:0] v;
    case (i)
      4'd0:    v = 17'sd8192;
      4'd1:    v = 17'sd4836;
      4'd2:    v = 17'sd2555;
      4'd3:    v = 17'sd1297;
      4'd4:    v = 17'sd651;
      4'd5:    v = 17'sd326;
      4'd6:    v = 17'sd163;
      4'd7:    v = 17'sd81;
      4'd8:    v = 17'sd41;
      4'd9:    v = 17'sd20;
      4'd10:   v = 17'sd10;
      4'd11:   v = 17'sd5;
      4'd12:   v = 17'sd3;
      4'd13:   v = 17'sd1;
      4'd14:   v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bpc_cordic.sv -----
// Iterative rotation CORDIC giving cosine and sine of a binary angle.
`timescale 1ns / 1ps
`default_nettype none
module bpc_cordic (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bpc_pkg::cord_req_t  req_i,
  output bpc_pkg::cord_rsp_t  rsp_o
);

  logic               run_q;
  logic               done_q;
  logic               flip_q;
  logic [3:0]         i_q;
  logic signed [33:0] x_q;
  logic signed [33:0] y_q;
  logic signed [16:0] z_q;
  logic signed [16:0] ang;
  logic signed [33:0] xs;
  logic signed [33:0] ys;

  assign ang = {req_i.angle[15], req_i.angle};
  assign xs  = y_q >>> i_q;
  assign ys  = x_q >>> i_q;

  // Sequence the sixteen micro-rotations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        run_q <= 1'b1;
        i_q   <= '0;
      end else if (run_q) begin
        if (i_q == 4'(bpc_pkg::CORDIC_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + 4'd1;
        end
      end
    end
  end

  // Fold the angle into the half turn around zero, then rotate
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      x_q <= bpc_pkg::CORDIC_K;
      y_q <= '0;
      if (ang > 17'sd16384) begin
        z_q    <= ang - 17'sd32768;
        flip_q <= 1'b1;
      end else if (ang < -17'sd16384) begin
        z_q    <= ang + 17'sd32768;
        flip_q <= 1'b1;
      end else begin
        z_q    <= ang;
        flip_q <= 1'b0;
      end
    end else if (run_q) begin
      if (!z_q[16]) begin
        x_q <= x_q - xs;
        y_q <= y_q + ys;
        z_q <= z_q - bpc_pkg::atan_val(i_q);
      end else begin
        x_q <= x_q + xs;
        y_q <= y_q - ys;
        z_q <= z_q + bpc_pkg::atan_val(i_q);
      end
    end
  end

  // Undo the fold by negating both results
  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = flip_q ? -x_q : x_q;
  assign rsp_o.sin_v = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

// ----- hdl/bpc_front.sv -----
// Front end: accepts words, works out the bounded yaw and queues them.
`timescale 1ns / 1ps
`default_nettype none
module bpc_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  bpc_pkg::pose_in_t   raw_i,
  input  wire  [16:0]         gain_i,
  input  wire  [14:0]         turn_i,
  input  wire                 pop_i,
  output logic                empty_o,
  output bpc_pkg::item_t      head_o
);

  bpc_pkg::item_t     mem_q [2];
  logic               wp_q;
  logic               rp_q;
  logic [1:0]         cnt_q;
  logic               push;
  logic [16:0]        alpha;
  logic signed [15:0] err;
  logic signed [33:0] tprod;
  logic signed [33:0] trnd;
  logic signed [17:0] turn_raw;
  logic signed [17:0] turn_lim;
  logic signed [17:0] turn;
  bpc_pkg::item_t     item_new;

  assign busy_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign push    = start_i && !busy_o;
  assign head_o  = mem_q[rp_q];

  // Saturate the gain and blend the wrapped yaw error
  always_comb begin
    alpha    = gain_i[16] ? bpc_pkg::GAIN_ONE : gain_i;
    err      = raw_i.mh - raw_i.ph;
    tprod    = $signed({1'b0, alpha}) * err;
    trnd     = tprod + 34'sd32768;
    turn_raw = trnd[33:16];
    turn_lim = $signed({3'b000, turn_i});
    turn     = turn_raw;
    if (turn_raw > turn_lim) begin
      turn = turn_lim;
    end else if (turn_raw < -turn_lim) begin
      turn = -turn_lim;
    end
    item_new.raw   = raw_i;
    item_new.yaw   = raw_i.ph + turn[15:0];
    item_new.alpha = alpha;
  end

  // Track queue fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Store the accepted word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= item_new;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/bpc_back.sv -----
// Back end: sequences rotations, blending, length limit and the final pose.
`timescale 1ns / 1ps
`default_nettype none
module bpc_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 empty_i,
  input  bpc_pkg::item_t      head_i,
  output logic                pop_o,
  input  wire  [30:0]         shift_i,
  output bpc_pkg::cord_req_t  cord_req_o,
  input  bpc_pkg::cord_rsp_t  cord_rsp_i,
  output logic                valid_o,
  output logic [31:0]         fixed_x_o,
  output logic [31:0]         fixed_y_o,
  output logic [15:0]         fixed_heading_o
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_CORD  = 11'b00000000010,
    ST_MUL   = 11'b00000000100,
    ST_POSE  = 11'b00000001000,
    ST_DIFF  = 11'b00000010000,
    ST_ABS   = 11'b00000100000,
    ST_SHIFT = 11'b00001000000,
    ST_SQRT  = 11'b00010000000,
    ST_CHK   = 11'b00100000000,
    ST_DIV   = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } bpc_state_e;

  // Angle jobs for the sine/cosine unit
  localparam logic [1:0] CJ_PRIOR = 2'd0;
  localparam logic [1:0] CJ_SEEN  = 2'd1;
  localparam logic [1:0] CJ_YAW   = 2'd2;

  // Product steps of the shared multiplier
  localparam logic [4:0] MU_CP_OX  = 5'd0;
  localparam logic [4:0] MU_SP_OY  = 5'd1;
  localparam logic [4:0] MU_SP_OX  = 5'd2;
  localparam logic [4:0] MU_CP_OY  = 5'd3;
  localparam logic [4:0] MU_CM_OX  = 5'd4;
  localparam logic [4:0] MU_SM_OY  = 5'd5;
  localparam logic [4:0] MU_SM_OX  = 5'd6;
  localparam logic [4:0] MU_CM_OY  = 5'd7;
  localparam logic [4:0] MU_GAIN_X = 5'd8;
  localparam logic [4:0] MU_GAIN_Y = 5'd9;
  localparam logic [4:0] MU_SQ_X   = 5'd10;
  localparam logic [4:0] MU_SQ_Y   = 5'd11;
  localparam logic [4:0] MU_LIM_X  = 5'd12;
  localparam logic [4:0] MU_LIM_Y  = 5'd13;
  localparam logic [4:0] MU_SY_OY  = 5'd14;
  localparam logic [4:0] MU_CY_OX  = 5'd15;
  localparam logic [4:0] MU_SY_OX  = 5'd16;
  localparam logic [4:0] MU_CY_OY  = 5'd17;

  bpc_state_e         state_q, state_d;
  logic [1:0]         cj_q;
  logic [4:0]         mi_q;
  logic               ph_q;
  logic               go_q;
  logic [4:0]         sqk_q;
  logic [4:0]         dk_q;
  logic               divy_q;
  logic [2:0]         sh_q;
  logic               valid_q;

  bpc_pkg::item_t     item_q;
  logic signed [33:0] cp_q, sp_q, cm_q, sm_q, cy_q, sy_q;
  logic signed [69:0] p_q;
  logic [65:0]        acc0_q, acc1_q, acc2_q, acc3_q;
  logic [35:0]        oldx_q, oldy_q, newx_q, newy_q;
  logic [35:0]        difx_q, dify_q;
  logic [35:0]        dx_q, dy_q;
  logic [35:0]        ax_q, ay_q;
  logic [30:0]        axs_q, ays_q;
  logic [63:0]        sqv_q, sqr_q;
  logic [32:0]        rem_q;
  logic [30:0]        num_q;
  logic [30:0]        quo_q;
  logic [31:0]        fx_q, fy_q;
  logic [15:0]        fh_q;

  logic signed [35:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [69:0] prod;
  logic signed [69:0] gsum;
  logic [35:0]        gval;
  logic [35:0]        mag;
  logic [63:0]        sbit;
  logic [63:0]        stry;
  logic [31:0]        ds;
  logic [39:0]        span;
  logic [33:0]        dtry;
  logic               qbit;
  logic [32:0]        rem_n;
  logic [30:0]        nx;
  logic [35:0]        nx_s;
  logic [35:0]        r0;
  logic [35:0]        r1;
  logic signed [37:0] fsx;
  logic signed [37:0] fsy;

  // Round a Q2.30 by Q16.16 product sum half up to Q16.16
  function automatic logic [35:0] rnd30(input logic [65:0] v);
    logic [65:0] t;
    t = v + (66'd1 << 29);
    return t[65:30];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign pop_o            = (state_q == ST_IDLE) && !empty_i;
  assign valid_o          = valid_q;
  assign fixed_x_o        = fx_q;
  assign fixed_y_o        = fy_q;
  assign fixed_heading_o  = fh_q;

  // Drive the request: start strobe and the angle of the current job
  always_comb begin
    cord_req_o.go = go_q;
    case (cj_q)
      CJ_PRIOR: cord_req_o.angle = item_q.raw.ph;
      CJ_SEEN:  cord_req_o.angle = item_q.raw.mh;
      default:  cord_req_o.angle = item_q.yaw;
    endcase
  end

  // Pick the operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (mi_q)
      MU_CP_OX:  begin mul_a = 36'(cp_q);   mul_b = 34'(item_q.raw.ox); end
      MU_SP_OY:  begin mul_a = 36'(sp_q);   mul_b = 34'(item_q.raw.oy); end
      MU_SP_OX:  begin mul_a = 36'(sp_q);   mul_b = 34'(item_q.raw.ox); end
      MU_CP_OY:  begin mul_a = 36'(cp_q);   mul_b = 34'(item_q.raw.oy); end
      MU_CM_OX:  begin mul_a = 36'(cm_q);   mul_b = 34'(item_q.raw.ox); end
      MU_SM_OY:  begin mul_a = 36'(sm_q);   mul_b = 34'(item_q.raw.oy); end
      MU_SM_OX:  begin mul_a = 36'(sm_q);   mul_b = 34'(item_q.raw.ox); end
      MU_CM_OY:  begin mul_a = 36'(cm_q);   mul_b = 34'(item_q.raw.oy); end
      MU_GAIN_X: begin
        mul_a = $signed(difx_q);
        mul_b = $signed({17'd0, item_q.alpha});
      end
      MU_GAIN_Y: begin
        mul_a = $signed(dify_q);
        mul_b = $signed({17'd0, item_q.alpha});
      end
      MU_SQ_X:   begin
        mul_a = $signed({5'd0, axs_q});
        mul_b = $signed({3'd0, axs_q});
      end
      MU_SQ_Y:   begin
        mul_a = $signed({5'd0, ays_q});
        mul_b = $signed({3'd0, ays_q});
      end
      MU_LIM_X:  begin
        mul_a = $signed({5'd0, axs_q});
        mul_b = $signed({3'd0, shift_i});
      end
      MU_LIM_Y:  begin
        mul_a = $signed({5'd0, ays_q});
        mul_b = $signed({3'd0, shift_i});
      end
      MU_SY_OY:  begin mul_a = 36'(sy_q);   mul_b = 34'(item_q.raw.oy); end
      MU_CY_OX:  begin mul_a = 36'(cy_q);   mul_b = 34'(item_q.raw.ox); end
      MU_SY_OX:  begin mul_a = 36'(sy_q);   mul_b = 34'(item_q.raw.ox); end
      MU_CY_OY:  begin mul_a = 36'(cy_q);   mul_b = 34'(item_q.raw.oy); end
      default:   begin mul_a = '0;          mul_b = '0;                 end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Gain product rounded half up from the Q1.16 gain
  assign gsum = p_q + 70'sd32768;
  assign gval = gsum[51:16];

  // Length limit helpers
  assign mag  = (ax_q > ay_q) ? ax_q : ay_q;
  assign sbit = 64'd1 << {sqk_q, 1'b0};
  assign stry = sqr_q + sbit;
  assign ds   = sqr_q[31:0];
  assign span = {8'd0, ds} << sh_q;

  // One restoring division step
  assign dtry  = {rem_q, num_q[30]};
  assign qbit  = (dtry >= {2'b00, ds});
  assign rem_n = qbit ? 33'(dtry - {2'b00, ds}) : dtry[32:0];
  assign nx    = {quo_q[29:0], qbit};
  assign nx_s  = {5'd0, nx};

  // Final sums: blended point minus the rotated odometry vector
  assign r0  = rnd30(acc0_q);
  assign r1  = rnd30(acc1_q);
  assign fsx = $signed({{2{oldx_q[35]}}, oldx_q}) + $signed({{2{dx_q[35]}}, dx_q})
             + $signed({{2{r0[35]}}, r0});
  assign fsy = $signed({{2{oldy_q[35]}}, oldy_q}) + $signed({{2{dy_q[35]}}, dy_q})
             + $signed({{2{r1[35]}}, r1});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!empty_i) state_d = ST_CORD;
      ST_CORD:  if (cord_rsp_i.done && cj_q != CJ_PRIOR) state_d = ST_MUL;
      ST_MUL: begin
        if (ph_q) begin
          case (mi_q)
            MU_CM_OY:            state_d = ST_POSE;
            MU_GAIN_Y:           state_d = ST_ABS;
            MU_SQ_Y:             state_d = ST_SQRT;
            MU_LIM_X, MU_LIM_Y:  state_d = ST_DIV;
            MU_CY_OY:            state_d = ST_OUT;
            default:             state_d = ST_MUL;
          endcase
        end
      end
      ST_POSE:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_MUL;
      ST_ABS:   state_d = ST_SHIFT;
      ST_SHIFT: if ((mag >> sh_q) <= 36'h0_7FFF_FFFF) state_d = ST_MUL;
      ST_SQRT:  if (sqk_q == 5'd0) state_d = ST_CHK;
      ST_CHK:   state_d = (span > {9'd0, shift_i}) ? ST_MUL : ST_CORD;
      ST_DIV:   if (dk_q == 5'd0) state_d = divy_q ? ST_CORD : ST_MUL;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cj_q    <= CJ_PRIOR;
      mi_q    <= MU_CP_OX;
      ph_q    <= 1'b0;
      go_q    <= 1'b0;
      sqk_q   <= '0;
      dk_q    <= '0;
      divy_q  <= 1'b0;
      sh_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= 1'b0;
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            cj_q <= CJ_PRIOR;
            go_q <= 1'b1;
          end
        end
        ST_CORD: begin
          if (cord_rsp_i.done) begin
            ph_q <= 1'b0;
            case (cj_q)
              CJ_PRIOR: begin
                cj_q <= CJ_SEEN;
                go_q <= 1'b1;
              end
              CJ_SEEN: mi_q <= MU_CP_OX;
              default: mi_q <= MU_SY_OY;
            endcase
          end
        end
        ST_MUL: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            case (mi_q)
              MU_SQ_Y:  sqk_q <= 5'd31;
              MU_LIM_X, MU_LIM_Y: begin
                dk_q   <= 5'd30;
                divy_q <= (mi_q == MU_LIM_Y);
              end
              MU_CM_OY, MU_GAIN_Y, MU_CY_OY: mi_q <= mi_q;
              default:  mi_q <= mi_q + 5'd1;
            endcase
          end
        end
        ST_POSE: ph_q <= 1'b0;
        ST_DIFF: mi_q <= MU_GAIN_X;
        ST_ABS:  sh_q <= '0;
        ST_SHIFT: begin
          if ((mag >> sh_q) > 36'h0_7FFF_FFFF) begin
            sh_q <= sh_q + 3'd1;
          end else begin
            mi_q <= MU_SQ_X;
            ph_q <= 1'b0;
          end
        end
        ST_SQRT: begin
          if (sqk_q != 5'd0) begin
            sqk_q <= sqk_q - 5'd1;
          end
        end
        ST_CHK: begin
          ph_q <= 1'b0;
          if (span > {9'd0, shift_i}) begin
            mi_q <= MU_LIM_X;
          end else begin
            cj_q <= CJ_YAW;
            go_q <= 1'b1;
          end
        end
        ST_DIV: begin
          if (dk_q != 5'd0) begin
            dk_q <= dk_q - 5'd1;
          end else if (divy_q) begin
            cj_q <= CJ_YAW;
            go_q <= 1'b1;
          end else begin
            mi_q <= MU_LIM_Y;
            ph_q <= 1'b0;
          end
        end
        ST_OUT:  valid_q <= 1'b1;
        default: valid_q <= 1'b0;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          item_q <= head_i;
        end
      end
      ST_CORD: begin
        if (cord_rsp_i.done) begin
          case (cj_q)
            CJ_PRIOR: begin cp_q <= cord_rsp_i.cos_v; sp_q <= cord_rsp_i.sin_v; end
            CJ_SEEN:  begin cm_q <= cord_rsp_i.cos_v; sm_q <= cord_rsp_i.sin_v; end
            default:  begin cy_q <= cord_rsp_i.cos_v; sy_q <= cord_rsp_i.sin_v; end
          endcase
        end
      end
      ST_MUL: begin
        if (!ph_q) begin
          p_q <= prod;
        end else begin
          case (mi_q)
            MU_CP_OX:  acc0_q <= p_q[65:0];
            MU_SP_OY:  acc0_q <= acc0_q - p_q[65:0];
            MU_SP_OX:  acc1_q <= p_q[65:0];
            MU_CP_OY:  acc1_q <= acc1_q + p_q[65:0];
            MU_CM_OX:  acc2_q <= p_q[65:0];
            MU_SM_OY:  acc2_q <= acc2_q - p_q[65:0];
            MU_SM_OX:  acc3_q <= p_q[65:0];
            MU_CM_OY:  acc3_q <= acc3_q + p_q[65:0];
            MU_GAIN_X: dx_q <= gval;
            MU_GAIN_Y: dy_q <= gval;
            MU_SQ_X:   sqv_q <= p_q[63:0];
            MU_SQ_Y: begin
              sqv_q <= sqv_q + p_q[63:0];
              sqr_q <= '0;
            end
            MU_LIM_X, MU_LIM_Y: begin
              rem_q <= {2'b00, p_q[61:31]};
              num_q <= p_q[30:0];
              quo_q <= '0;
            end
            MU_SY_OY:  acc0_q <= p_q[65:0];
            MU_CY_OX:  acc0_q <= acc0_q - p_q[65:0];
            MU_SY_OX:  acc1_q <= 66'd0 - p_q[65:0];
            MU_CY_OY:  acc1_q <= acc1_q - p_q[65:0];
            default:   acc0_q <= acc0_q;
          endcase
        end
      end
      ST_POSE: begin
        oldx_q <= 36'(item_q.raw.px) + rnd30(acc0_q);
        oldy_q <= 36'(item_q.raw.py) + rnd30(acc1_q);
        newx_q <= 36'(item_q.raw.mx) + rnd30(acc2_q);
        newy_q <= 36'(item_q.raw.my) + rnd30(acc3_q);
      end
      ST_DIFF: begin
        difx_q <= newx_q - oldx_q;
        dify_q <= newy_q - oldy_q;
      end
      ST_ABS: begin
        ax_q <= dx_q[35] ? 36'd0 - dx_q : dx_q;
        ay_q <= dy_q[35] ? 36'd0 - dy_q : dy_q;
      end
      ST_SHIFT: begin
        axs_q <= 31'(ax_q >> sh_q);
        ays_q <= 31'(ay_q >> sh_q);
      end
      ST_SQRT: begin
        if (sqv_q >= stry) begin
          sqv_q <= sqv_q - stry;
          sqr_q <= (sqr_q >> 1) + sbit;
        end else begin
          sqr_q <= sqr_q >> 1;
        end
      end
      ST_DIV: begin
        rem_q <= rem_n;
        num_q <= {num_q[29:0], 1'b0};
        quo_q <= nx;
        if (dk_q == 5'd0) begin
          if (divy_q) begin
            dy_q <= dy_q[35] ? 36'd0 - nx_s : nx_s;
          end else begin
            dx_q <= dx_q[35] ? 36'd0 - nx_s : nx_s;
          end
        end
      end
      ST_OUT: begin
        fx_q <= sat32(fsx);
        fy_q <= sat32(fsy);
        fh_q <= item_q.yaw;
      end
      default: fh_q <= fh_q;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/bounded_pose_correction.sv -----
// Bounded pose correction: valid_o rises when the back end has finished a word, which
// takes a pre-shift when the blended difference needs one and two divisions under the
// length limit. The work is three CORDIC runs, a 32-step square root and sixteen
// products (eighteen and two 31-step divisions under the limit) through one multiplier;
// a two-word queue takes new words while the back end works, until it is full.
// Reset clears the queue and the sequencer; the registers return to gain 1.0.
`timescale 1ns / 1ps
`default_nettype none
module bounded_pose_correction (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [30:0] cfg_data_i,
  input  wire  [31:0] prior_x_i,
  input  wire  [31:0] prior_y_i,
  input  wire  [15:0] prior_heading_i,
  input  wire  [31:0] seen_x_i,
  input  wire  [31:0] seen_y_i,
  input  wire  [15:0] seen_heading_i,
  input  wire  [31:0] odo_x_i,
  input  wire  [31:0] odo_y_i,
  output logic        valid_o,
  output logic [31:0] fixed_x_o,
  output logic [31:0] fixed_y_o,
  output logic [15:0] fixed_heading_o
);

  logic [16:0]          gain_q;
  logic [30:0]          shift_q;
  logic [14:0]          turn_q;
  bpc_pkg::pose_in_t    raw;
  bpc_pkg::item_t       head;
  logic                 empty;
  logic                 pop;
  bpc_pkg::cord_req_t   cord_req;
  bpc_pkg::cord_rsp_t   cord_rsp;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= bpc_pkg::GAIN_RST;
      shift_q <= bpc_pkg::SHIFT_RST;
      turn_q  <= bpc_pkg::TURN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpc_pkg::CFG_GAIN:  gain_q  <= cfg_data_i[16:0];
        bpc_pkg::CFG_SHIFT: shift_q <= cfg_data_i;
        bpc_pkg::CFG_TURN:  turn_q  <= cfg_data_i[14:0];
        default:            gain_q  <= gain_q;
      endcase
    end
  end

  // Gather the input word
  always_comb begin
    raw.px = prior_x_i;
    raw.py = prior_y_i;
    raw.ph = prior_heading_i;
    raw.mx = seen_x_i;
    raw.my = seen_y_i;
    raw.mh = seen_heading_i;
    raw.ox = odo_x_i;
    raw.oy = odo_y_i;
  end

  bpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .raw_i   (raw),
    .gain_i  (gain_q),
    .turn_i  (turn_q),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  bpc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cord_req),
    .rsp_o  (cord_rsp)
  );

  bpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .shift_i         (shift_q),
    .cord_req_o      (cord_req),
    .cord_rsp_i      (cord_rsp),
    .valid_o         (valid_o),
    .fixed_x_o       (fixed_x_o),
    .fixed_y_o       (fixed_y_o),
    .fixed_heading_o (fixed_heading_o)
  );

endmodule
`default_nettype wire
